[design/knn3_pkg.sv]
// Shared types and constants for the nearest-three-points selector.
// Used by the distance pipeline, the ranking cell and the top level.
package knn3_pkg;

	localparam int COORD_W = 24;
	localparam int MAG_W   = 24;
	localparam int SQ_W    = 48;
	localparam int DIST_W  = 50;
	localparam int IDX_W   = 17;
	localparam int CFG_W   = 2;
	localparam int OUT_K   = 3;

	localparam logic [CFG_W-1:0] REG_CENTER_X = 2'd0;
	localparam logic [CFG_W-1:0] REG_CENTER_Y = 2'd1;
	localparam logic [CFG_W-1:0] REG_CENTER_Z = 2'd2;

	// Control carried alongside a point through the distance pipeline.
	typedef struct packed {
		logic             vld;
		logic             last;
		logic             rank;
		logic             ovf;
		logic [IDX_W-1:0] idx;
	} tag_t;

	// Contents of one ranking slot.
	typedef struct packed {
		logic              vld;
		logic [DIST_W-1:0] dsq;
		logic [IDX_W-1:0]  idx;
	} slot_t;

endpackage

[design/knn3_dist.sv]
// Three-stage squared-distance pipeline: difference and magnitude, squares, sum.
// Depends on knn3_pkg.
module knn3_dist import knn3_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  tag_t                      tag,
	input  logic signed [COORD_W-1:0] px,
	input  logic signed [COORD_W-1:0] py,
	input  logic signed [COORD_W-1:0] pz,
	input  logic signed [COORD_W-1:0] cx,
	input  logic signed [COORD_W-1:0] cy,
	input  logic signed [COORD_W-1:0] cz,
	output tag_t                      tag_s3,
	output logic [DIST_W-1:0]         dist_s3
);

	logic [COORD_W:0] dx, dy, dz;
	logic [COORD_W:0] ax, ay, az;
	tag_t             tag_s1, tag_s2;
	logic [MAG_W-1:0] mx_s1, my_s1, mz_s1;
	logic [SQ_W-1:0]  sx_s2, sy_s2, sz_s2;

	assign dx = {px[COORD_W-1], px} - {cx[COORD_W-1], cx};
	assign dy = {py[COORD_W-1], py} - {cy[COORD_W-1], cy};
	assign dz = {pz[COORD_W-1], pz} - {cz[COORD_W-1], cz};
	assign ax = dx[COORD_W] ? -dx : dx;
	assign ay = dy[COORD_W] ? -dy : dy;
	assign az = dz[COORD_W] ? -dz : dz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else if (en) begin
			tag_s1 <= tag;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1   <= ax[MAG_W-1:0];
			my_s1   <= ay[MAG_W-1:0];
			mz_s1   <= az[MAG_W-1:0];
			sx_s2   <= mx_s1 * mx_s1;
			sy_s2   <= my_s1 * my_s1;
			sz_s2   <= mz_s1 * mz_s1;
			dist_s3 <= DIST_W'(sx_s2) + DIST_W'(sy_s2) + DIST_W'(sz_s2);
		end
	end

endmodule

[design/knn3_cell.sv]
// One ranking slot of the sorted chain; takes the new point or its neighbour's entry.
// Depends on knn3_pkg.
module knn3_cell import knn3_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              ins_en,
	input  logic              clear,
	input  logic [DIST_W-1:0] new_dist,
	input  logic [IDX_W-1:0]  new_idx,
	input  slot_t             prev,
	input  logic              prev_take,
	output slot_t             slot_q,
	output slot_t             slot_d,
	output logic              take
);

	assign take = ins_en && (!slot_q.vld || (new_dist < slot_q.dsq));

	always_comb begin
		slot_d = slot_q;
		if (take && prev_take) begin
			slot_d = prev;
		end else if (take) begin
			slot_d.vld = 1'b1;
			slot_d.dsq = new_dist;
			slot_d.idx = new_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '{vld: 1'b0, dsq: '1, idx: '0};
		end else if (clear) begin
			slot_q <= '{vld: 1'b0, dsq: '1, idx: '0};
		end else begin
			slot_q <= slot_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) !prev.vld |-> !slot_q.vld)
		else $error("Occupied slot follows an empty one.");
	assert property (@(posedge clk) disable iff (!arst_n)
		(prev.vld && slot_q.vld) |-> (prev.dsq <= slot_q.dsq))
		else $error("Slot chain is out of distance order.");

endmodule

[design/nearest_three_points_select_top.sv]
// Top level of the nearest-three-points selector: counter, centre registers, result register.
// Depends on knn3_pkg, knn3_dist and knn3_cell.
//
//  Channel  Handshake              Carries
//  in       in_valid / in_stall    point_x, point_y, point_z, last_point
//  out      out_valid / out_stall  nearest_first/second/third, found_count, count_overflow
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request is taken every cycle while in_stall is low; a point is written into the slot chain
// once it leaves the distance pipeline.
// The latency is set by the difference, square and sum stages ahead of the chain.
// The result of a last point is registered at the same edge as that chain update.
// in_stall rises only while a result is held and a further last point waits behind it.
// Reset empties the chain, zeroes the count and the centre registers.
module nearest_three_points_select_top import knn3_pkg::*; #(
	parameter int MAX_POINTS = 65536,
	parameter int KEEP_COUNT = 3
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [COORD_W-1:0] point_x,
	input  logic signed [COORD_W-1:0] point_y,
	input  logic signed [COORD_W-1:0] point_z,
	input  logic                      last_point,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [IDX_W-1:0]          nearest_first,
	output logic [IDX_W-1:0]          nearest_second,
	output logic [IDX_W-1:0]          nearest_third,
	output logic [1:0]                found_count,
	output logic                      count_overflow,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_W-1:0]          cfg_index,
	input  logic [COORD_W-1:0]        cfg_data
);

	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int NR = (KEEP_COUNT < OUT_K) ? KEEP_COUNT : OUT_K;

	logic signed [COORD_W-1:0] cx_q, cy_q, cz_q;
	logic [CW-1:0]             cnt_q;
	logic                      ovf_q;
	logic                      accept, ranked, en, hold;
	logic [CW+IDX_W-1:0]       idx_wide;
	tag_t                      tag_in, tag_s3;
	logic [DIST_W-1:0]         dist_s3;
	logic                      ins_en, clear;
	slot_t                     slot_q [KEEP_COUNT];
	slot_t                     slot_d [KEEP_COUNT];
	slot_t                     prev   [KEEP_COUNT];
	logic                      take   [KEEP_COUNT];
	logic                      ptake  [KEEP_COUNT];
	logic [IDX_W-1:0]          res_idx [OUT_K];
	logic [1:0]                res_cnt;
	logic                      out_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
			cz_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CENTER_X: cx_q <= cfg_data;
				REG_CENTER_Y: cy_q <= cfg_data;
				REG_CENTER_Z: cz_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign hold     = tag_s3.vld && tag_s3.last && out_valid_q && out_stall;
	assign en       = !hold;
	assign in_stall = hold;
	assign accept   = in_valid && !in_stall;
	assign ranked   = cnt_q < CW'(MAX_POINTS);
	assign idx_wide = {{IDX_W{1'b0}}, cnt_q} + (CW+IDX_W)'(1);

	assign tag_in.vld  = accept;
	assign tag_in.last = last_point;
	assign tag_in.rank = ranked;
	assign tag_in.ovf  = ovf_q || !ranked;
	assign tag_in.idx  = idx_wide[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (accept) begin
			if (last_point) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				if (ranked) begin
					cnt_q <= cnt_q + CW'(1);
				end
				if (!ranked) begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	knn3_dist u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.tag     (tag_in),
		.px      (point_x),
		.py      (point_y),
		.pz      (point_z),
		.cx      (cx_q),
		.cy      (cy_q),
		.cz      (cz_q),
		.tag_s3  (tag_s3),
		.dist_s3 (dist_s3)
	);

	assign ins_en = en && tag_s3.vld && tag_s3.rank;
	assign clear  = en && tag_s3.vld && tag_s3.last;

	for (genvar j = 0; j < KEEP_COUNT; j++) begin : g_cell
		if (j == 0) begin : g_head
			assign prev[j]  = '{vld: 1'b1, dsq: '0, idx: '0};
			assign ptake[j] = 1'b0;
		end else begin : g_link
			assign prev[j]  = slot_q[j-1];
			assign ptake[j] = take[j-1];
		end
		knn3_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ins_en    (ins_en),
			.clear     (clear),
			.new_dist  (dist_s3),
			.new_idx   (tag_s3.idx),
			.prev      (prev[j]),
			.prev_take (ptake[j]),
			.slot_q    (slot_q[j]),
			.slot_d    (slot_d[j]),
			.take      (take[j])
		);
	end

	for (genvar k = 0; k < OUT_K; k++) begin : g_res
		if (k < KEEP_COUNT) begin : g_slot
			assign res_idx[k] = slot_d[k].vld ? slot_d[k].idx : '0;
		end else begin : g_none
			assign res_idx[k] = '0;
		end
	end

	always_comb begin
		res_cnt = '0;
		for (int k = 0; k < NR; k++) begin
			res_cnt = res_cnt + 2'(slot_d[k].vld);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (clear) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clear) begin
			nearest_first  <= res_idx[0];
			nearest_second <= res_idx[1];
			nearest_third  <= res_idx[2];
			found_count    <= res_cnt;
			count_overflow <= tag_s3.ovf;
		end
	end

	assign out_valid = out_valid_q;

	assert property (@(posedge clk) disable iff (!arst_n) in_stall |-> (out_valid && out_stall))
		else $error("Input stalled without a held result.");
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && last_point) |=> (cnt_q == '0 && !ovf_q))
		else $error("Point count not cleared after the last point.");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((found_count == 2'd0) == (nearest_first == '0)))
		else $error("Found count disagrees with the first index.");
	assert property (@(posedge clk) disable iff (!arst_n)
		clear |=> out_valid)
		else $error("Result lost after a last point.");

endmodule
